@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the text blitter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, no reset qualifier
`define CBT_ASSERT_CLK(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

// clocked check, off while the active-low reset is asserted
`define CBT_ASSERT(lbl, clk, rst_n, prop, msg) \
	`CBT_ASSERT_CLK(lbl, clk, disable iff (!rst_n) prop, msg)

`endif

@@ rtl/cbt_pkg.sv @@
// ----------------------------------------------------------------------------
// cbt_pkg
// Types, constants and helpers of the clipped 8x8 font text blitter.
// ----------------------------------------------------------------------------
package cbt_pkg;

	localparam int GLYPH_COUNT = 256;
	localparam int COORD_BITS  = 12;
	localparam int STORE_DEPTH = GLYPH_COUNT * 8;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int GLYPH_W     = $clog2(GLYPH_COUNT);
	localparam int SCR_W       = 10;
	localparam int COLOR_W     = 16;
	localparam int POS_W       = 12;
	localparam int FADDR_W     = 11;
	localparam int WIDE_W      = 17;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 10;
	localparam int COORD_MAX   = (1 << (COORD_BITS - 1)) - 1;
	localparam int COORD_MIN   = -COORD_MAX - 1;
	localparam int GLYPH_STEP  = 8;

	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_PEN  = 2'd1;
	localparam logic [1:0] CMD_DRAW = 2'd2;

	localparam logic [7:0] CHAR_NL = 8'h0A;
	localparam logic [7:0] CHAR_CR = 8'h0D;

	localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_RIGHT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_BOTTOM = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WIDE_COLOR  = 3'd4;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		logic [1:0]              command;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic [7:0]              char_code;
		logic [COLOR_W-1:0]      ink_color;
		logic [FADDR_W-1:0]      font_address;
		logic [7:0]              font_byte;
	} cmd_t;

	typedef struct packed {
		logic [SCR_W-1:0]   pixel_x;
		logic [SCR_W-1:0]   pixel_y;
		logic [COLOR_W-1:0] pixel_color;
		logic               last_pixel;
	} pix_t;

	typedef struct packed {
		logic [SCR_W-1:0] left;
		logic [SCR_W-1:0] top;
		logic [SCR_W-1:0] right;
		logic [SCR_W-1:0] bottom;
	} clip_t;

	typedef struct packed {
		logic               valid;
		logic [GLYPH_W-1:0] code;
		logic [COLOR_W-1:0] ink;
		coord_t             col;
		coord_t             row;
	} start_t;

	function automatic coord_t clamp_pos(input logic signed [POS_W-1:0] v);
		logic signed [WIDE_W-1:0] w;
		logic signed [WIDE_W-1:0] hi;
		logic signed [WIDE_W-1:0] lo;
		w  = WIDE_W'(v);
		hi = WIDE_W'(COORD_MAX);
		lo = WIDE_W'(COORD_MIN);
		if (w > hi)
			return COORD_BITS'(hi);
		if (w < lo)
			return COORD_BITS'(lo);
		return COORD_BITS'(w);
	endfunction

	function automatic coord_t step8(input coord_t v);
		logic signed [COORD_BITS:0] s;
		logic signed [COORD_BITS:0] hi;
		s  = (COORD_BITS + 1)'(v) + (COORD_BITS + 1)'(GLYPH_STEP);
		hi = (COORD_BITS + 1)'(COORD_MAX);
		if (s > hi)
			return COORD_BITS'(hi);
		return COORD_BITS'(s);
	endfunction

	function automatic logic in_clip(input logic signed [COORD_BITS:0] p,
			input logic [SCR_W-1:0] lo, input logic [SCR_W-1:0] hi);
		logic signed [COORD_BITS:0] lo_e;
		logic signed [COORD_BITS:0] hi_e;
		lo_e = (COORD_BITS + 1)'({1'b0, lo});
		hi_e = (COORD_BITS + 1)'({1'b0, hi});
		return (p >= lo_e) && (p <= hi_e);
	endfunction

endpackage

@@ rtl/clipped_font_text_blitter.sv @@
// ----------------------------------------------------------------------------
// clipped_font_text_blitter
// 8x8 bitmap font text renderer with a clip window.
// ----------------------------------------------------------------------------
// Command words enter on cmd/cmd_valid/cmd_stall; pixel words leave on
// pix/pix_valid/pix_stall. Clip window and colour mode are written through
// cfg_we/cfg_index/cfg_data; the user must write them only while the block
// is idle, as the block itself does not enforce it. Font load, set-pen,
// newline and carriage return do not hold cmd_stall and give no pixel words.
// A draw holds cmd_stall high while its glyph is scanned: for each of the 8
// rows the sequencer addresses the font store (one read port, registered
// read data) in ST_READ, masks the row by the clip window in ST_LOAD and
// emits each visible pixel in ST_EMIT, then ST_FLUSH sends the held-back
// pixel, if any. Pixel words are held back by one so the last one can carry
// last_pixel. A stalled pixel word holds in the output register; the scan
// waits while the held-back pixel is full and the output register holds a
// stalled word. Reset clears the pen to zero and loads the clip window
// 0..639 x 0..479 with 16-bit colour. The font store is not cleared: load
// every glyph row before it is drawn.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module clipped_font_text_blitter (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cmd_valid,
	output logic                               cmd_stall,
	input  cbt_pkg::cmd_t                      cmd,
	output logic                               pix_valid,
	input  logic                               pix_stall,
	output cbt_pkg::pix_t                      pix,
	input  logic                               cfg_we,
	input  logic [cbt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cbt_pkg::CFG_DATA_W-1:0]     cfg_data
);

	cbt_pkg::clip_t               clip_q;
	logic                         wide_q;
	cbt_pkg::coord_t              pen_col_q;
	cbt_pkg::coord_t              pen_row_q;
	cbt_pkg::coord_t              line_col_q;

	logic                         eng_busy;
	logic                         accept;
	logic                         is_load;
	logic                         is_pen;
	logic                         is_draw;
	logic                         is_nl;
	logic                         is_cr;
	logic                         ram_we;
	logic [cbt_pkg::ADDR_W-1:0]   ram_raddr;
	logic [7:0]                   ram_rdata;
	cbt_pkg::start_t              start;

	assign cmd_stall = eng_busy;
	assign accept    = cmd_valid && !cmd_stall;
	assign is_load   = accept && (cmd.command == cbt_pkg::CMD_LOAD);
	assign is_pen    = accept && (cmd.command == cbt_pkg::CMD_PEN);
	assign is_draw   = accept && (cmd.command == cbt_pkg::CMD_DRAW);
	assign is_nl     = cmd.char_code == cbt_pkg::CHAR_NL;
	assign is_cr     = cmd.char_code == cbt_pkg::CHAR_CR;
	assign ram_we    = is_load &&
		({1'b0, cmd.font_address} < (cbt_pkg::FADDR_W + 1)'(cbt_pkg::STORE_DEPTH));

	always_comb begin
		start.valid = is_draw && !is_nl && !is_cr &&
			({1'b0, cmd.char_code} < 9'(cbt_pkg::GLYPH_COUNT));
		start.code  = cmd.char_code[cbt_pkg::GLYPH_W-1:0];
		start.ink   = wide_q ? cmd.ink_color : {8'h00, cmd.ink_color[7:0]};
		start.col   = pen_col_q;
		start.row   = pen_row_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_q.left   <= 10'd0;
			clip_q.top    <= 10'd0;
			clip_q.right  <= 10'd639;
			clip_q.bottom <= 10'd479;
			wide_q        <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cbt_pkg::REG_CLIP_LEFT:   clip_q.left   <= cfg_data;
				cbt_pkg::REG_CLIP_TOP:    clip_q.top    <= cfg_data;
				cbt_pkg::REG_CLIP_RIGHT:  clip_q.right  <= cfg_data;
				cbt_pkg::REG_CLIP_BOTTOM: clip_q.bottom <= cfg_data;
				cbt_pkg::REG_WIDE_COLOR:  wide_q        <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_col_q  <= '0;
			pen_row_q  <= '0;
			line_col_q <= '0;
		end else if (is_pen) begin
			pen_col_q  <= cbt_pkg::clamp_pos(cmd.pos_x);
			pen_row_q  <= cbt_pkg::clamp_pos(cmd.pos_y);
			line_col_q <= cbt_pkg::clamp_pos(cmd.pos_x);
		end else if (is_draw && is_nl) begin
			pen_col_q <= line_col_q;
			pen_row_q <= cbt_pkg::step8(pen_row_q);
		end else if (is_draw && !is_cr) begin
			pen_col_q <= cbt_pkg::step8(pen_col_q);
		end
	end

	cbt_font_ram u_font_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cmd.font_address[cbt_pkg::ADDR_W-1:0]),
		.wdata (cmd.font_byte),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	cbt_raster u_raster (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.clip      (clip_q),
		.busy      (eng_busy),
		.raddr     (ram_raddr),
		.rdata     (ram_rdata),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix)
	);

	`CBT_ASSERT(a_no_load_in_draw, clk, arst_n, ram_we |-> !eng_busy, "font write during draw")
	`CBT_ASSERT(a_start_when_idle, clk, arst_n, start.valid |-> !eng_busy, "draw start while busy")
	`CBT_ASSERT(a_pix_from_draw, clk, arst_n, $rose(pix_valid) |-> $past(eng_busy), "pixel without draw")

endmodule

@@ rtl/cbt_font_ram.sv @@
// ----------------------------------------------------------------------------
// cbt_font_ram
// Glyph row store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cbt_font_ram (
	input  logic                      clk,
	input  logic                      we,
	input  logic [cbt_pkg::ADDR_W-1:0] waddr,
	input  logic [7:0]                wdata,
	input  logic [cbt_pkg::ADDR_W-1:0] raddr,
	output logic [7:0]                rdata
);

	logic [7:0] mem [cbt_pkg::STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/cbt_raster.sv @@
// ----------------------------------------------------------------------------
// cbt_raster
// Glyph sequencer: reads rows from the font store, emits visible pixels.
// ----------------------------------------------------------------------------
module cbt_raster (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cbt_pkg::start_t            start,
	input  cbt_pkg::clip_t             clip,
	output logic                       busy,
	output logic [cbt_pkg::ADDR_W-1:0] raddr,
	input  logic [7:0]                 rdata,
	output logic                       pix_valid,
	input  logic                       pix_stall,
	output cbt_pkg::pix_t              pix
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_READ  = 3'd1;
	localparam logic [2:0] ST_LOAD  = 3'd2;
	localparam logic [2:0] ST_EMIT  = 3'd3;
	localparam logic [2:0] ST_FLUSH = 3'd4;

	localparam int CW = cbt_pkg::COORD_BITS + 1;

	logic [2:0]                         state_q;
	logic [cbt_pkg::GLYPH_W-1:0]        code_q;
	logic [cbt_pkg::COLOR_W-1:0]        ink_q;
	cbt_pkg::coord_t                    col_q;
	cbt_pkg::coord_t                    row_q;
	logic [2:0]                         line_q;
	logic [7:0]                         colvis_q;
	logic                               rowvis_q;
	logic [cbt_pkg::SCR_W-1:0]          py_q;
	logic [7:0]                         mask_q;
	logic                               pend_valid_q;
	logic [cbt_pkg::SCR_W-1:0]          pend_x_q;
	logic [cbt_pkg::SCR_W-1:0]          pend_y_q;
	logic                               out_valid_q;
	cbt_pkg::pix_t                      out_q;

	logic [7:0]                         colvis_d;
	logic signed [CW-1:0]               py_full;
	logic                               found;
	logic [2:0]                         pick_c;
	logic [cbt_pkg::SCR_W-1:0]          pick_x;
	logic                               out_free;
	logic                               take;
	logic                               flush;

	always_comb begin
		logic signed [CW-1:0] p;
		colvis_d = '0;
		for (int c = 0; c < 8; c++) begin
			p = CW'(start.col) + CW'(c);
			colvis_d[7-c] = cbt_pkg::in_clip(p, clip.left, clip.right);
		end
	end

	always_comb begin
		found  = 1'b0;
		pick_c = '0;
		for (int c = 0; c < 8; c++) begin
			if (!found && mask_q[7-c]) begin
				found  = 1'b1;
				pick_c = 3'(c);
			end
		end
	end

	assign py_full  = CW'(row_q) + CW'({1'b0, line_q});
	assign pick_x   = col_q[cbt_pkg::SCR_W-1:0] + cbt_pkg::SCR_W'(pick_c);
	assign out_free = !out_valid_q || !pix_stall;
	assign take     = (state_q == ST_EMIT) && found && (!pend_valid_q || out_free);
	assign flush    = (state_q == ST_FLUSH) && pend_valid_q && out_free;
	assign raddr    = {code_q, line_q};
	assign busy     = (state_q != ST_IDLE);
	assign pix_valid = out_valid_q;
	assign pix      = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start.valid)
						state_q <= ST_READ;
				end
				ST_READ: state_q <= ST_LOAD;
				ST_LOAD: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (!found)
						state_q <= (line_q == 3'd7) ? ST_FLUSH : ST_READ;
				end
				ST_FLUSH: begin
					if (!pend_valid_q || out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (take)
				pend_valid_q <= 1'b1;
			else if (flush)
				pend_valid_q <= 1'b0;
			if ((take && pend_valid_q) || flush)
				out_valid_q <= 1'b1;
			else if (!pix_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start.valid) begin
			code_q   <= start.code;
			ink_q    <= start.ink;
			col_q    <= start.col;
			row_q    <= start.row;
			line_q   <= '0;
			colvis_q <= colvis_d;
		end
		if (state_q == ST_READ) begin
			rowvis_q <= cbt_pkg::in_clip(py_full, clip.top, clip.bottom);
			py_q     <= py_full[cbt_pkg::SCR_W-1:0];
		end
		if (state_q == ST_LOAD)
			mask_q <= rdata & colvis_q & {8{rowvis_q}};
		if (state_q == ST_EMIT && !found)
			line_q <= line_q + 3'd1;
		if (take) begin
			mask_q   <= mask_q & ~(8'h80 >> pick_c);
			pend_x_q <= pick_x;
			pend_y_q <= py_q;
		end
		if ((take && pend_valid_q) || flush) begin
			out_q.pixel_x     <= pend_x_q;
			out_q.pixel_y     <= pend_y_q;
			out_q.pixel_color <= ink_q;
			out_q.last_pixel  <= flush;
		end
	end

endmodule

@@ verif/clipped_font_text_blitter_check.sv @@
// ----------------------------------------------------------------------------
// clipped_font_text_blitter_check
// Watches the command, pixel and register ports of the text blitter, keeps
// its own font store, pen and clip window, renders every accepted draw into
// a queue of pixel words and compares each accepted pixel word against it.
// ----------------------------------------------------------------------------
module clipped_font_text_blitter_check (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	input  logic                           cmd_stall,
	input  cbt_pkg::cmd_t                  cmd,
	input  logic                           pix_valid,
	input  logic                           pix_stall,
	input  cbt_pkg::pix_t                  pix,
	input  logic                           cfg_we,
	input  logic [cbt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cbt_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             mismatches,
	output int                             pixels_owed
);
	import cbt_pkg::*;

	logic [7:0] font [STORE_DEPTH];
	int         pen_x;
	int         pen_y;
	int         line_x;
	clip_t      window;
	logic       wide;
	pix_t       pixels_due [$];
	pix_t       due;
	int         errs;

	function automatic int saturate(input int v);
		if (v > COORD_MAX)
			return COORD_MAX;
		if (v < COORD_MIN)
			return COORD_MIN;
		return v;
	endfunction

	// Hold each pixel back by one so the final one can be flagged.
	function automatic void render_glyph(input logic [7:0] code,
			input logic [COLOR_W-1:0] ink);
		pix_t             held;
		bit               have;
		int               px;
		int               py;
		logic [7:0]       bits;
		logic [COLOR_W-1:0] color;
		have = 1'b0;
		color = wide ? ink : {8'h00, ink[7:0]};
		for (int r = 0; r < 8; r++) begin
			py = pen_y + r;
			bits = font[{code, 3'(r)}];
			if (py >= int'(window.top) && py <= int'(window.bottom)) begin
				for (int c = 0; c < 8; c++) begin
					px = pen_x + c;
					if (bits[7 - c] && px >= int'(window.left) && px <= int'(window.right)) begin
						if (have)
							pixels_due.push_back(held);
						held.pixel_x = SCR_W'(px);
						held.pixel_y = SCR_W'(py);
						held.pixel_color = color;
						held.last_pixel = 1'b0;
						have = 1'b1;
					end
				end
			end
		end
		if (have) begin
			held.last_pixel = 1'b1;
			pixels_due.push_back(held);
		end
		pen_x = saturate(pen_x + GLYPH_STEP);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x = 0;
			pen_y = 0;
			line_x = 0;
			window.left = 10'd0;
			window.top = 10'd0;
			window.right = 10'd639;
			window.bottom = 10'd479;
			wide = 1'b1;
			pixels_due.delete();
			errs = 0;
			mismatches <= 0;
			pixels_owed <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_CLIP_LEFT:   window.left = cfg_data;
					REG_CLIP_TOP:    window.top = cfg_data;
					REG_CLIP_RIGHT:  window.right = cfg_data;
					REG_CLIP_BOTTOM: window.bottom = cfg_data;
					REG_WIDE_COLOR:  wide = cfg_data[0];
					default: ;
				endcase
			end
			if (cmd_valid && !cmd_stall) begin
				case (cmd.command)
					CMD_LOAD: font[cmd.font_address] = cmd.font_byte;
					CMD_PEN: begin
						pen_x = saturate(int'(cmd.pos_x));
						pen_y = saturate(int'(cmd.pos_y));
						line_x = pen_x;
					end
					CMD_DRAW: begin
						if (cmd.char_code == CHAR_NL) begin
							pen_x = line_x;
							pen_y = saturate(pen_y + GLYPH_STEP);
						end else if (cmd.char_code != CHAR_CR) begin
							render_glyph(cmd.char_code, cmd.ink_color);
						end
					end
					default: ;
				endcase
			end
			if (pix_valid && !pix_stall) begin
				if (pixels_due.size() == 0) begin
					$error("pixel word with none expected: x %0d y %0d color %h",
						pix.pixel_x, pix.pixel_y, pix.pixel_color);
					errs++;
				end else begin
					due = pixels_due.pop_front();
					if (pix.pixel_x !== due.pixel_x) begin
						$error("pixel_x: expected %0d, got %0d", due.pixel_x, pix.pixel_x);
						errs++;
					end
					if (pix.pixel_y !== due.pixel_y) begin
						$error("pixel_y: expected %0d, got %0d", due.pixel_y, pix.pixel_y);
						errs++;
					end
					if (pix.pixel_color !== due.pixel_color) begin
						$error("pixel_color: expected %h, got %h", due.pixel_color,
							pix.pixel_color);
						errs++;
					end
					if (pix.last_pixel !== due.last_pixel) begin
						$error("last_pixel: expected %0b, got %0b", due.last_pixel,
							pix.last_pixel);
						errs++;
					end
				end
			end
			mismatches <= errs;
			pixels_owed <= pixels_due.size();
		end
	end

endmodule

@@ verif/clipped_font_text_blitter_test.sv @@
// ----------------------------------------------------------------------------
// clipped_font_text_blitter_test
// Drives font loads, pen moves and draws through several clip windows and
// colour modes, with random gaps and receiver stalls and one long receiver
// hold-off, while the checker predicts and compares every pixel word.
// ----------------------------------------------------------------------------
module clipped_font_text_blitter_test;
	import cbt_pkg::*;

	localparam logic [1:0] CMD_NOP = 2'd3;
	localparam int HOLD_CYCLES  = 200;
	localparam int DRAIN_CYCLES = 100;
	localparam int STALL_LIMIT  = 2000;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cmd_valid;
	logic                  cmd_stall;
	cmd_t                  cmd;
	logic                  pix_valid;
	logic                  pix_stall;
	pix_t                  pix;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    mismatches;
	int                    pixels_owed;

	bit    quiet;
	bit    hold_req;
	bit    rx_calm;
	bit    tx_calm;
	bit    glyph_ready [256];
	int    ready_codes [$];
	clip_t window;

	always #5 clk = ~clk;

	clipped_font_text_blitter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	clipped_font_text_blitter_check watch (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.cmd         (cmd),
		.pix_valid   (pix_valid),
		.pix_stall   (pix_stall),
		.pix         (pix),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.pixels_owed (pixels_owed)
	);

	function automatic cmd_t word_of(input logic [1:0] op);
		cmd_t w;
		w.command = op;
		w.pos_x = POS_W'($urandom);
		w.pos_y = POS_W'($urandom);
		w.char_code = 8'($urandom);
		w.ink_color = COLOR_W'($urandom);
		w.font_address = FADDR_W'($urandom);
		w.font_byte = 8'($urandom);
		return w;
	endfunction

	function automatic int near(input int lo, input int hi);
		if ($urandom_range(0, 7) == 0)
			return int'($signed(POS_W'($urandom)));
		if (lo > hi)
			return int'($urandom_range(0, 1023));
		return int'($urandom_range(0, hi - lo + 16)) + lo - 12;
	endfunction

	function automatic logic [COLOR_W-1:0] random_ink();
		if ($urandom_range(0, 7) == 0)
			return 16'hFFFF;
		return COLOR_W'($urandom);
	endfunction

	task automatic put(input cmd_t w);
		if ($urandom_range(0, 15) == 0)
			tx_calm = !tx_calm;
		if (!quiet && !tx_calm && $urandom_range(0, 3) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		cmd <= w;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall);
	endtask

	task automatic load_glyph(input logic [7:0] code, input logic [63:0] rows);
		cmd_t w;
		for (int r = 0; r < 8; r++) begin
			w = word_of(CMD_LOAD);
			w.font_address = {code, 3'(r)};
			w.font_byte = rows[63 - 8 * r -: 8];
			put(w);
		end
		if (!glyph_ready[code]) begin
			glyph_ready[code] = 1'b1;
			ready_codes.push_back(code);
		end
	endtask

	task automatic pen(input int x, input int y);
		cmd_t w;
		w = word_of(CMD_PEN);
		w.pos_x = POS_W'(x);
		w.pos_y = POS_W'(y);
		put(w);
	endtask

	task automatic draw(input logic [7:0] code, input logic [COLOR_W-1:0] ink);
		cmd_t w;
		w = word_of(CMD_DRAW);
		w.char_code = code;
		w.ink_color = ink;
		put(w);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(v);
		@(posedge clk);
	endtask

	task automatic configure(input int l, input int t, input int r, input int b,
			input bit wide);
		write_reg(REG_CLIP_LEFT, l);
		write_reg(REG_CLIP_TOP, t);
		write_reg(REG_CLIP_RIGHT, r);
		write_reg(REG_CLIP_BOTTOM, b);
		write_reg(REG_WIDE_COLOR, int'(wide));
		cfg_we <= 1'b0;
		window.left = SCR_W'(l);
		window.top = SCR_W'(t);
		window.right = SCR_W'(r);
		window.bottom = SCR_W'(b);
	endtask

	// Drop valid, wait out owed pixels, then let a draw with no pixels finish.
	task automatic settle();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (pixels_owed != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_random(input int n);
		int            done;
		int            pick;
		logic [63:0]   rows;
		done = 0;
		while (done < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 10 || ready_codes.size() == 0) begin
				rows = {$urandom, $urandom};
				if ($urandom_range(0, 3) == 0)
					rows &= {$urandom, $urandom};
				load_glyph(8'($urandom), rows);
				done += 8;
			end else begin
				if (pick < 16)
					put(word_of(CMD_LOAD));
				else if (pick < 28)
					pen(near(int'(window.left), int'(window.right)),
						near(int'(window.top), int'(window.bottom)));
				else if (pick < 33)
					draw(CHAR_NL, random_ink());
				else if (pick < 36)
					draw(CHAR_CR, random_ink());
				else if (pick < 39)
					put(word_of(CMD_NOP));
				else
					draw(8'(ready_codes[$urandom_range(0, ready_codes.size() - 1)]),
						random_ink());
				done++;
			end
		end
	endtask

	initial begin
		int left;
		left = 0;
		pix_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 63) == 0)
				rx_calm = !rx_calm;
			if (left > 0) begin
				left--;
				pix_stall <= 1'b1;
			end else if (hold_req) begin
				hold_req = 1'b0;
				left = HOLD_CYCLES - 1;
				pix_stall <= 1'b1;
			end else if (!quiet && !rx_calm && $urandom_range(0, 3) == 0) begin
				left = $urandom_range(0, 2);
				pix_stall <= 1'b1;
			end else begin
				pix_stall <= 1'b0;
			end
		end
	end

	initial begin
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((cmd_valid && !cmd_stall) || (pix_valid && !pix_stall))
				idle = 0;
			else
				idle++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		cmd_valid <= 1'b0;
		cmd <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_CLIP_LEFT;
		cfg_data <= '0;
		window.left = 10'd0;
		window.top = 10'd0;
		window.right = 10'd639;
		window.bottom = 10'd479;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		load_glyph(8'hFF, 64'hFF80_0100_AA55_817E);
		begin
			cmd_t w;
			w = word_of(CMD_LOAD);
			w.font_address = '0;
			w.font_byte = 8'h00;
			put(w);
		end
		pen(0, 0);
		draw(8'hFF, 16'hFFFF);
		draw(8'hFF, 16'h0000);
		draw(CHAR_NL, 16'h1234);
		draw(CHAR_CR, 16'h5678);
		put(word_of(CMD_NOP));
		pen(2047, 2047);
		draw(8'hFF, 16'hA5A5);
		draw(CHAR_NL, 16'h0F0F);
		pen(-2048, -2048);
		draw(8'hFF, 16'h5A5A);
		pen(-4, -3);
		draw(8'hFF, 16'hFFFF);
		draw(8'hFF, 16'h8001);
		pen(636, 476);
		draw(8'hFF, 16'h7FFE);
		settle();

		configure(0, 0, 1023, 1023, 1'b0);
		hold_req = 1'b1;
		pen(1020, 1020);
		draw(8'hFF, 16'hFFFF);
		run_random(50);
		settle();

		configure(100, 50, 163, 97, 1'b1);
		run_random(40);
		settle();

		configure(600, 0, 10, 1023, 1'b1);
		run_random(15);
		settle();

		configure(0, 900, 1023, 3, 1'b0);
		run_random(15);
		settle();

		configure($urandom_range(0, 1023), $urandom_range(0, 1023),
			$urandom_range(0, 1023), $urandom_range(0, 1023), 1'($urandom));
		run_random(40);
		settle();

		quiet = 1'b1;
		configure(0, 0, 639, 479, 1'b1);
		run_random(40);
		settle();

		if (mismatches == 0 && pixels_owed == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/cbt_pkg.sv
rtl/cbt_font_ram.sv
rtl/cbt_raster.sv
rtl/clipped_font_text_blitter.sv
verif/clipped_font_text_blitter_check.sv
verif/clipped_font_text_blitter_test.sv
